[design/csl_pkg.sv]
// Shared types, constants and keyword tables for the C-subset lexer.
`default_nettype none
package csl_pkg;

    localparam int MaxToken = 64;
    localparam int MaxLine  = 4095;
    localparam int KwNum    = 15;
    localparam int QDepth   = 4;
    localparam int QAw      = 2;

    localparam logic [5:0] K_IDENT  = 6'd15;
    localparam logic [5:0] K_INT    = 6'd38;
    localparam logic [5:0] K_STRING = 6'd39;
    localparam logic [5:0] K_CHAR   = 6'd40;

    localparam logic [2:0] E_NONE   = 3'd0;
    localparam logic [2:0] E_BANG   = 3'd1;
    localparam logic [2:0] E_QUOTE  = 3'd2;
    localparam logic [2:0] E_EMPTY  = 3'd3;
    localparam logic [2:0] E_BADCH  = 3'd4;
    localparam logic [2:0] E_BADSTR = 3'd5;
    localparam logic [2:0] E_UNEXP  = 3'd6;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_IDENT = 11'b00000000010,
        S_NUM   = 11'b00000000100,
        S_LT    = 11'b00000001000,
        S_GT    = 11'b00000010000,
        S_EQ    = 11'b00000100000,
        S_BANG  = 11'b00001000000,
        S_CQ1   = 11'b00010000000,
        S_CBAD  = 11'b00100000000,
        S_CQ2   = 11'b01000000000,
        S_STR   = 11'b10000000000
    } scan_state_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } lex_in_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [30:0] token_value;
        logic [6:0]  token_length;
        logic [2:0]  error_code;
        logic [15:0] line_number;
        logic [11:0] column;
        logic        last_of_run;
    } lex_out_t;

    // one classified item on its way to the back end: up to two results
    typedef struct packed {
        logic     two;
        lex_out_t first;
        lex_out_t second;
    } lex_pair_t;

    function automatic logic [2:0] kw_len(input int i);
        logic [2:0] l;
        case (i)
            0: l = 3'd5;  1: l = 3'd3;  2: l = 3'd4;  3: l = 3'd4;  4: l = 3'd4;
            5: l = 3'd2;  6: l = 3'd4;  7: l = 3'd2;  8: l = 3'd5;  9: l = 3'd6;
            10: l = 3'd4; 11: l = 3'd7; 12: l = 3'd5; 13: l = 3'd6;
            default: l = 3'd6;
        endcase
        return l;
    endfunction

    function automatic logic [55:0] kw_text(input int i);
        logic [55:0] t;
        case (i)
            0: t = "const";  1: t = "int";    2: t = "char";   3: t = "void";
            4: t = "main";   5: t = "if";     6: t = "else";   7: t = "do";
            8: t = "while";  9: t = "switch"; 10: t = "case";  11: t = "default";
            12: t = "scanf"; 13: t = "printf";
            default: t = "return";
        endcase
        return t;
    endfunction

    // character at position p of keyword i (text is right aligned)
    function automatic logic [7:0] kw_char(input int i, input logic [2:0] p);
        logic [55:0] t;
        logic [2:0]  l;
        logic [2:0]  sh;
        t  = kw_text(i);
        l  = kw_len(i);
        sh = 3'(l - 3'd1 - p);
        return t[{sh, 3'b000} +: 8];
    endfunction

endpackage
`default_nettype wire

[design/csl_front.sv]
// Front end: scanner state machine that classifies each character into results.
`default_nettype none
module csl_front
    import csl_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      take,
    input  wire lex_in_t   item,
    output lex_pair_t      pair,
    output logic           pair_any
);
    scan_state_t  st_reg, st_next;
    logic [14:0]  cand_reg, cand_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [30:0]  num_reg, num_next;
    logic [7:0]   lit_reg, lit_next;
    logic         quo_reg, quo_next;
    logic [15:0]  line_reg, line_next;
    logic [11:0]  col_reg, col_next;

    logic [7:0]   c;
    lex_out_t     r [2];
    logic [1:0]   n;
    logic         rescan;
    logic [34:0]  prod;
    logic [5:0]   kind1;
    logic         is_let, is_dig, is_ws;
    logic [5:0]   wkind;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            r[i] = '0;
            r[i].line_number = line_reg;
            r[i].column = col_reg;
        end
        n = 2'd0;
        rescan = 1'b0;
        kind1 = 6'd0;
        wkind = K_IDENT;
        st_next = st_reg; cand_next = cand_reg; cnt_next = cnt_reg;
        num_next = num_reg; lit_next = lit_reg; quo_next = quo_reg;
        line_next = line_reg; col_next = col_reg;
        c = item.char_code;
        if (!quo_reg && c >= "A" && c <= "Z")
            c = c + 8'd32;
        is_let = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
        is_dig = c >= "0" && c <= "9";
        is_ws  = (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
        prod = {4'd0, num_reg} * 35'd10 + {27'd0, c - 8'd48};
        for (int i = 0; i < KwNum; i++)
            if (cand_reg[i] && {4'd0, kw_len(i)} == cnt_reg)
                wkind = 6'(i);

        if (item.end_of_input)
        begin
            r[0].column = col_reg;
            unique case (st_reg)
                S_IDENT: begin r[0].token_kind = wkind; r[0].token_length = cnt_reg; n = 2'd1; end
                S_NUM:
                begin
                    r[0].token_kind = K_INT; r[0].token_value = num_reg;
                    r[0].token_length = cnt_reg; n = 2'd1;
                end
                S_LT: begin r[0].token_kind = 6'd20; r[0].token_length = 7'd1; n = 2'd1; end
                S_GT: begin r[0].token_kind = 6'd22; r[0].token_length = 7'd1; n = 2'd1; end
                S_EQ: begin r[0].token_kind = 6'd28; r[0].token_length = 7'd1; n = 2'd1; end
                S_BANG: begin r[0].error_code = E_BANG; n = 2'd1; end
                S_CQ1:
                begin
                    r[0].error_code = E_BADCH; r[1].error_code = E_QUOTE; n = 2'd2;
                end
                S_CBAD, S_CQ2: begin r[0].error_code = E_QUOTE; n = 2'd1; end
                S_STR: begin r[0].error_code = E_BADSTR; n = 2'd1; end
                default: ;
            endcase
            st_next = S_IDLE; cnt_next = '0; num_next = '0; cand_next = '1;
        end
        else
        begin
            if (c == "'" || c == "\"")
                quo_next = !quo_reg;
            if (c == 8'd10)
            begin
                if (line_reg != 16'hFFFF)
                    line_next = line_reg + 16'd1;
                col_next = '0;
            end
            else if (col_reg < 12'(MaxLine))
                col_next = col_reg + 12'd1;

            unique case (st_reg)
                S_IDENT:
                begin
                    if (is_let || is_dig)
                    begin
                        if (cnt_reg >= 7'(MaxToken))
                            cand_next = '0;
                        else
                        begin
                            for (int i = 0; i < KwNum; i++)
                                if (!(cnt_reg < {4'd0, kw_len(i)} &&
                                      kw_char(i, cnt_reg[2:0]) == c))
                                    cand_next[i] = 1'b0;
                            cnt_next = cnt_reg + 7'd1;
                        end
                    end
                    else
                    begin
                        r[0].token_kind = wkind; r[0].token_length = cnt_reg;
                        n = 2'd1; rescan = 1'b1;
                    end
                end
                S_NUM:
                begin
                    if (is_dig)
                    begin
                        num_next = prod > 35'h7FFFFFFF ? 31'h7FFFFFFF : prod[30:0];
                        if (cnt_reg < 7'(MaxToken))
                            cnt_next = cnt_reg + 7'd1;
                    end
                    else
                    begin
                        r[0].token_kind = K_INT; r[0].token_value = num_reg;
                        r[0].token_length = cnt_reg; n = 2'd1; rescan = 1'b1;
                    end
                end
                S_LT, S_GT, S_EQ:
                begin
                    n = 2'd1;
                    if (c == "=")
                    begin
                        r[0].token_kind = st_reg == S_LT ? 6'd21 : st_reg == S_GT ? 6'd23 : 6'd25;
                        r[0].token_length = 7'd2;
                        st_next = S_IDLE;
                    end
                    else
                    begin
                        r[0].token_kind = st_reg == S_LT ? 6'd20 : st_reg == S_GT ? 6'd22 : 6'd28;
                        r[0].token_length = 7'd1;
                        rescan = 1'b1;
                    end
                end
                S_BANG:
                begin
                    n = 2'd1; st_next = S_IDLE;
                    if (c == "=")
                    begin
                        r[0].token_kind = 6'd24; r[0].token_length = 7'd2;
                    end
                    else
                        r[0].error_code = E_BANG;
                end
                S_CQ1:
                begin
                    if (c == "+" || c == "-" || c == "*" || c == "/" || is_let || is_dig)
                    begin
                        lit_next = c; st_next = S_CQ2;
                    end
                    else if (c == "'")
                    begin
                        r[0].error_code = E_EMPTY; n = 2'd1; st_next = S_IDLE;
                    end
                    else
                    begin
                        r[0].error_code = E_BADCH; n = 2'd1; st_next = S_CBAD;
                    end
                end
                S_CBAD:
                begin
                    st_next = S_IDLE;
                    if (c != "'")
                    begin
                        r[0].error_code = E_QUOTE; n = 2'd1; rescan = 1'b1;
                    end
                end
                S_CQ2:
                begin
                    st_next = S_IDLE; n = 2'd1;
                    if (c == "'")
                    begin
                        r[0].token_kind = K_CHAR; r[0].token_value = {23'd0, lit_reg};
                        r[0].token_length = 7'd3;
                    end
                    else
                        r[0].error_code = E_QUOTE;
                end
                S_STR:
                begin
                    if (c == "\"")
                    begin
                        r[0].token_kind = K_STRING;
                        r[0].token_length = cnt_reg < 7'(MaxToken) ? cnt_reg + 7'd1 : cnt_reg;
                        n = 2'd1; st_next = S_IDLE;
                    end
                    else if (c == 8'd32 || c == 8'd33 || (c >= 8'd35 && c <= 8'd126))
                    begin
                        if (cnt_reg < 7'(MaxToken))
                            cnt_next = cnt_reg + 7'd1;
                    end
                    else
                    begin
                        r[0].error_code = E_BADSTR; n = 2'd1; rescan = 1'b1;
                    end
                end
                default: rescan = 1'b1;
            endcase
            if (st_next == S_IDLE)
            begin
                cnt_next = '0; num_next = '0; cand_next = '1;
            end
            if (rescan)
            begin
                st_next = S_IDLE; cnt_next = '0; num_next = '0; cand_next = '1;
                if (is_ws)
                    ;
                else if (is_let)
                begin
                    st_next = S_IDENT;
                    for (int i = 0; i < KwNum; i++)
                        if (kw_char(i, 3'd0) != c)
                            cand_next[i] = 1'b0;
                    cnt_next = 7'd1;
                end
                else if (is_dig)
                begin
                    st_next = S_NUM; cnt_next = 7'd1; num_next = {23'd0, c - 8'd48};
                end
                else
                begin
                    case (c)
                        "+": kind1 = 6'd16;
                        "-": kind1 = 6'd17;
                        "*": kind1 = 6'd18;
                        "/": kind1 = 6'd19;
                        ";": kind1 = 6'd26;
                        ",": kind1 = 6'd27;
                        ":": kind1 = 6'd29;
                        "{": kind1 = 6'd32;
                        "}": kind1 = 6'd33;
                        "(": kind1 = 6'd34;
                        ")": kind1 = 6'd35;
                        "[": kind1 = 6'd36;
                        "]": kind1 = 6'd37;
                        "<": st_next = S_LT;
                        ">": st_next = S_GT;
                        "=": st_next = S_EQ;
                        "!": st_next = S_BANG;
                        "'": st_next = S_CQ1;
                        "\"": begin st_next = S_STR; cnt_next = 7'd1; end
                        default: kind1 = 6'd0;
                    endcase
                    if (kind1 != 6'd0 || st_next == S_IDLE)
                    begin
                        r[n[0]].token_kind = kind1;
                        r[n[0]].token_length = kind1 != 6'd0 ? 7'd1 : 7'd0;
                        r[n[0]].error_code = kind1 != 6'd0 ? E_NONE : E_UNEXP;
                        n = n + 2'd1;
                    end
                end
            end
        end
        pair.two = n == 2'd2;
        pair.first = r[0];
        pair.second = r[1];
        if (n == 2'd2)
            pair.second.last_of_run = 1'b1;
        else
            pair.first.last_of_run = 1'b1;
        pair_any = n != 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; cand_reg <= '1; cnt_reg <= '0; num_reg <= '0;
            lit_reg <= '0; quo_reg <= 1'b0; line_reg <= 16'd1; col_reg <= '0;
        end
        else if (take)
        begin
            st_reg <= st_next; cand_reg <= cand_next; cnt_reg <= cnt_next;
            num_reg <= num_next; lit_reg <= lit_next; quo_reg <= quo_next;
            line_reg <= line_next; col_reg <= col_next;
        end
    end
endmodule
`default_nettype wire

[design/csl_back.sv]
// Back end: queue of classified items, delivering results one transaction at a time.
`default_nettype none
module csl_back
    import csl_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr,
    input  wire lex_pair_t wdata,
    output logic           full,
    output logic           empty,
    input  wire logic      pop,
    output lex_out_t       rdata
);
    lex_pair_t      mem [QDepth];
    logic [QAw-1:0] wp_reg, rp_reg;
    logic [QAw:0]   cnt_reg;
    logic           half_reg;
    logic           rd_done;

    assign full  = cnt_reg == (QAw+1)'(QDepth);
    assign empty = cnt_reg == '0;
    assign rdata = half_reg ? mem[rp_reg].second : mem[rp_reg].first;
    assign rd_done = pop && !empty && (half_reg || !mem[rp_reg].two);

    always_ff @(posedge clk)
    begin
        if (wr && !full)
            mem[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0; half_reg <= 1'b0;
        end
        else
        begin
            if (wr && !full)
                wp_reg <= wp_reg + 1'b1;
            if (pop && !empty)
                half_reg <= !rd_done;
            if (rd_done)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QAw+1)'(wr && !full) - (QAw+1)'(rd_done);
        end
    end
endmodule
`default_nettype wire

[design/c_subset_lexer_core.sv]
// Top level of the C-subset lexer: front scanner feeding a result queue.
// Takes one character per cycle unless full; each character is classified in
// the cycle it is pushed and yields zero, one or two results, which wait in a
// four-entry queue. Full rises only when that queue holds four characters'
// worth of results; a character with two results takes two pops to drain.
`default_nettype none
module c_subset_lexer_core
    import csl_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    output logic         full,
    input  wire lex_in_t in_item,
    output logic         empty,
    input  wire logic    pop,
    output lex_out_t     out_item
);
    lex_pair_t pair;
    logic      pair_any;
    logic      take;

    assign take = push && !full;

    csl_front u_front (
        .clk(clk), .rst_n(rst_n), .take(take), .item(in_item),
        .pair(pair), .pair_any(pair_any)
    );

    csl_back u_back (
        .clk(clk), .rst_n(rst_n), .wr(take && pair_any), .wdata(pair),
        .full(full), .empty(empty), .pop(pop), .rdata(out_item)
    );
endmodule
`default_nettype wire

[design/csl_checker.sv]
// Port-level checks of the lexer core, bound to the top level.
`default_nettype none
module csl_checker
    import csl_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     full,
    input wire logic     empty,
    input wire logic     pop,
    input wire lex_out_t out_item
);
    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && out_item.error_code != E_NONE |-> out_item.token_kind == 6'd0)
        else $error("error result with kind");
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> out_item.token_length <= 7'(MaxToken))
        else $error("length too large");
    a_line: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> out_item.line_number != 16'd0)
        else $error("line zero");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_item))
        else $error("result dropped");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("full while empty");
endmodule

bind c_subset_lexer_core csl_checker u_chk (
    .clk(clk), .rst_n(rst_n), .full(full),
    .empty(empty), .pop(pop), .out_item(out_item)
);
`default_nettype wire
